// ===== rtl/pgp_pkg.sv =====
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared widths, register indexes, status codes and the element mask helper
// for the planar gradient predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package pgp_pkg;

    // payload and register widths
    localparam int ELEM_W     = 64;
    localparam int ROW_W_W    = 13;
    localparam int ROWS_W     = 16;
    localparam int ESC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH  = 2'd0,
        REG_IMAGE_ROWS = 2'd1,
        REG_ELEM_SIZE  = 2'd2
    } t_cfg_reg;

    // element size codes
    typedef enum logic [ESC_W-1:0] {
        ELEM_8  = 2'd0,
        ELEM_16 = 2'd1,
        ELEM_32 = 2'd2,
        ELEM_64 = 2'd3
    } t_elem_size;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_WIDTH = 1'b1;

    typedef logic [ELEM_W-1:0] t_elem;

    // low-bit mask for the selected element width
    function automatic t_elem elem_mask(input logic [ESC_W-1:0] code);
        t_elem m;
        unique case (t_elem_size'(code))
            ELEM_8:  m = t_elem'(64'h0000_0000_0000_00FF);
            ELEM_16: m = t_elem'(64'h0000_0000_0000_FFFF);
            ELEM_32: m = t_elem'(64'h0000_0000_FFFF_FFFF);
            ELEM_64: m = t_elem'(64'hFFFF_FFFF_FFFF_FFFF);
            default: m = t_elem'(64'hFFFF_FFFF_FFFF_FFFF);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pgp_if.sv =====
// ----------------------------------------------------------------------------
// pgp_if
// Valid/ready channel interfaces: sample input, residual output and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgp_in_if;
    import pgp_pkg::*;
    logic  valid;
    logic  ready;
    t_elem sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pgp_out_if;
    import pgp_pkg::*;
    logic  valid;
    logic  ready;
    t_elem residual;
    logic  status;
    logic  end_of_image;

    modport source (output valid, output residual, output status,
                    output end_of_image, input ready);
    modport sink   (input valid, input residual, input status,
                    input end_of_image, output ready);
endinterface

interface pgp_cfg_if;
    import pgp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/planar_gradient_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// planar_gradient_predictor_unit
// Raster residual generator: sample minus (west + north - northwest), with a
// line store holding the previous row.
// ----------------------------------------------------------------------------
// Stages: input stage register, then output register. Throughput: one word per
// cycle while the output is not stalled; the line store read is registered,
// so the north value joins the sample one stage after acceptance.
// Reset: clears counters, neighbor registers, pipeline valids and sets the
// registers to row_width 0, image_rows 1, 8-bit elements. The line store is
// not cleared; the first row forces its north value to zero.
`default_nettype none

module planar_gradient_predictor_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pgp_cfg_if.sink   i_cfg,
    pgp_in_if.sink    i_in,
    pgp_out_if.source o_out
);
    import pgp_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = 18;

    // configuration registers
    logic [ROW_W_W-1:0] r_row_width;
    logic [ROWS_W-1:0]  r_image_rows;
    logic [ESC_W-1:0]   r_elem_size;

    // position counters
    logic [COL_W-1:0]  r_col,  n_col;
    logic [ROWS_W-1:0] r_row,  n_row;

    // input stage
    logic              r_a_valid;
    t_elem             r_a_sample;
    t_elem             r_a_mask;
    logic [COL_W-1:0]  r_a_col;
    logic              r_a_bad;
    logic              r_a_eoi;
    logic              r_a_row0;
    logic              r_a_col0;

    // write-to-read bypass for the line store
    logic              r_byp_hit;
    t_elem             r_byp_data;

    // neighbor registers
    t_elem             r_west;
    t_elem             r_nw;

    // output register
    logic              r_o_valid;
    t_elem             r_o_residual;
    logic              r_o_status;
    logic              r_o_eoi;

    logic              in_acc;
    logic              advance;
    logic              width_ok;
    logic              col_end;
    logic              img_end;
    logic              ram_we;
    t_elem             ram_q;
    t_elem             cur_mask;
    t_elem             north_raw;
    t_elem             north;
    t_elem             west;
    t_elem             nwest;
    t_elem             pred;
    t_elem             residual;

    // configuration writes, always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= '0;
            r_image_rows <= ROWS_W'(1);
            r_elem_size  <= ESC_W'(ELEM_8);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_ROW_WIDTH:  r_row_width  <= i_cfg.data[ROW_W_W-1:0];
                REG_IMAGE_ROWS: r_image_rows <= i_cfg.data[ROWS_W-1:0];
                REG_ELEM_SIZE:  r_elem_size  <= i_cfg.data[ESC_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = r_a_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || advance;
    assign in_acc     = i_in.valid && i_in.ready;

    // row width check and end-of-row/image detection
    assign width_ok = (r_row_width != '0) &&
                      (CMP_W'(r_row_width) <= CMP_W'(MAX_WIDTH));
    assign col_end  = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(r_row_width);
    assign img_end  = col_end &&
                      ((CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(r_image_rows));
    assign cur_mask = elem_mask(r_elem_size);

    // counter next values
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc && width_ok) begin
            if (col_end) begin
                n_col = '0;
                n_row = img_end ? '0 : r_row + ROWS_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // input stage capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sample <= i_in.sample & cur_mask;
            r_a_mask   <= cur_mask;
            r_a_col    <= r_col;
            r_a_bad    <= !width_ok;
            r_a_eoi    <= img_end;
            r_a_row0   <= (r_row == '0);
            r_a_col0   <= (r_col == '0);
            r_byp_hit  <= ram_we && (r_a_col == r_col);
            r_byp_data <= r_a_sample;
        end
    end

    // line store: written as a valid-width sample leaves the input stage
    assign ram_we = advance && !r_a_bad;

    pgp_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_a_col),
        .i_wdata (r_a_sample),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    // planar prediction and residual
    assign north_raw = r_byp_hit ? r_byp_data : ram_q;
    assign north     = r_a_row0 ? '0 : (north_raw & r_a_mask);
    assign west      = r_a_col0 ? '0 : (r_west & r_a_mask);
    assign nwest     = (r_a_row0 || r_a_col0) ? '0 : (r_nw & r_a_mask);
    assign pred      = (west + north - nwest) & r_a_mask;
    assign residual  = (r_a_sample - pred) & r_a_mask;

    // neighbor update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west <= '0;
            r_nw   <= '0;
        end else if (ram_we) begin
            r_west <= r_a_sample;
            r_nw   <= north;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_residual <= r_a_bad ? '0 : residual;
            r_o_status   <= r_a_bad ? STATUS_BAD_WIDTH : STATUS_OK;
            r_o_eoi      <= r_a_bad ? 1'b0 : r_a_eoi;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.residual     = r_o_residual;
    assign o_out.status       = r_o_status;
    assign o_out.end_of_image = r_o_eoi;

    // checks
    a_bad_no_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == STATUS_BAD_WIDTH) |-> !r_o_eoi)
        else $error("end_of_image set on a bad-width word");

    a_bad_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !width_ok) |=> ($stable(r_col) && $stable(r_row)))
        else $error("position moved on a bad-width word");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_o_valid) |=> r_o_valid)
        else $error("input stage did not drain into an empty output register");

endmodule

`default_nettype wire

// ===== rtl/pgp_ram.sv =====
// ----------------------------------------------------------------------------
// pgp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pgp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
